### hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg - shared types and constants of the rational arithmetic unit
// Operand and result widths, operation codes, front-to-back request format.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int NUM_OUT_W     = 33;
	localparam int DEN_OUT_W     = 32;
	localparam int OP_W          = 3;

	// full-precision signed cross-product result and its magnitude
	localparam int PROD_W = 2 * OPERAND_WIDTH;
	localparam int FULL_W = 2 * OPERAND_WIDTH + 1;
	localparam int MAG_W  = 2 * OPERAND_WIDTH + 1;
	localparam int CNT_W  = $clog2(MAG_W + 1);

	localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
	localparam logic [OP_W-1:0] OP_RECIP = 3'd4;

	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
	typedef logic [MAG_W-1:0] mag_t;

	// how the back part treats a request
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_REDUCE  = 2'd0;
	localparam kind_t KIND_ZERODEN = 2'd1;
	localparam kind_t KIND_BADOP   = 2'd2;

	typedef struct packed {
		kind_t kind;
		logic  num_neg;
		logic  den_neg;
		mag_t  num_mag;
		mag_t  den_mag;
	} req_t;

endpackage

### hw/rtl/rau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front - operand intake and classification
// Stage 1 forms the cross products, stage 2 combines them and classifies.
// ----------------------------------------------------------------------------
module rau_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [rau_pkg::OP_W-1:0]        op,
	input  rau_pkg::operand_t               a_num,
	input  rau_pkg::operand_t               a_den,
	input  rau_pkg::operand_t               b_num,
	input  rau_pkg::operand_t               b_den,
	output logic                            req_push,
	output rau_pkg::req_t                   req,
	input  logic                            req_full
);
	import rau_pkg::*;

	logic                     valid_s1, valid_s2;
	logic [OP_W-1:0]          op_s1;
	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1;
	operand_t                 an_s1, ad_s1;
	req_t                     req_s2;

	logic                     ready_s2, ready_s1, take;
	logic signed [FULL_W-1:0] num, den;
	kind_t                    kind;
	operand_t                 m0, m2;

	assign ready_s2 = !valid_s2 || !req_full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign full     = !ready_s1;
	assign take     = push && ready_s1;
	assign req_push = valid_s2 && !req_full;
	assign req      = req_s2;

	assign m0 = (op == OP_MUL) ? b_num : b_den;
	assign m2 = (op == OP_DIV) ? b_num : b_den;

	always_comb begin
		kind = KIND_REDUCE;
		num  = '0;
		den  = FULL_W'(p2_s1);
		unique case (op_s1)
			OP_ADD:   num = FULL_W'(p0_s1) + FULL_W'(p1_s1);
			OP_SUB:   num = FULL_W'(p0_s1) - FULL_W'(p1_s1);
			OP_MUL,
			OP_DIV:   num = FULL_W'(p0_s1);
			OP_RECIP: begin
				num = FULL_W'(ad_s1);
				den = FULL_W'(an_s1);
			end
			default:  kind = KIND_BADOP;
		endcase
		if (kind == KIND_REDUCE && den == '0)
			kind = KIND_ZERODEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= push;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op;
			p0_s1 <= a_num * m0;
			p1_s1 <= b_num * a_den;
			p2_s1 <= a_den * m2;
			an_s1 <= a_num;
			ad_s1 <= a_den;
		end
		if (ready_s2 && valid_s1) begin
			req_s2.kind    <= kind;
			req_s2.num_neg <= num[FULL_W-1];
			req_s2.den_neg <= den[FULL_W-1];
			req_s2.num_mag <= num[FULL_W-1] ? MAG_W'(-num) : MAG_W'(num);
			req_s2.den_mag <= den[FULL_W-1] ? MAG_W'(-den) : MAG_W'(den);
		end
	end

endmodule

### hw/rtl/rau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_queue - two-entry request queue between front and back
// ----------------------------------------------------------------------------
module rau_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  rau_pkg::req_t wr_data,
	output logic          q_full,
	input  logic          rd,
	output rau_pkg::req_t rd_data,
	output logic          q_empty
);
	import rau_pkg::*;

	req_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr)
				wptr_q <= !wptr_q;
			if (rd)
				rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_data;
	end

endmodule

### hw/rtl/rau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div - bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder valid when done is high.
// ----------------------------------------------------------------------------
module rau_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rau_pkg::mag_t        dividend,
	input  rau_pkg::mag_t        divisor,
	output logic                 done,
	output rau_pkg::mag_t        quo,
	output rau_pkg::mag_t        rem
);
	import rau_pkg::*;

	mag_t             rem_q, quo_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [MAG_W:0]   shifted;
	logic [MAG_W+1:0] diff;

	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign quo     = quo_q;
	assign rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (diff[MAG_W+1]) begin
				rem_q <= shifted[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end else begin
				rem_q <= diff[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end
		end
	end

endmodule

### hw/rtl/rau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back - Euclid reduction and result register
// Runs the gcd on the shared divider, divides both terms by it, holds result.
// ----------------------------------------------------------------------------
module rau_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rau_pkg::req_t                       req,
	input  logic                                q_empty,
	output logic                                req_pop,
	input  logic                                pop,
	output logic                                empty,
	output logic signed [rau_pkg::NUM_OUT_W-1:0] res_num,
	output logic signed [rau_pkg::DEN_OUT_W-1:0] res_den,
	output logic                                zero_den
);
	import rau_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GCD  = 3'd1;
	localparam logic [2:0] ST_NUMQ = 3'd2;
	localparam logic [2:0] ST_DENQ = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]               state_q;
	req_t                     cur_q;
	mag_t                     big_q, small_q, g_q, nq_q;
	logic                     out_valid_q;
	logic signed [NUM_OUT_W-1:0] fin_num_q;
	logic signed [DEN_OUT_W-1:0] fin_den_q;
	logic                     fin_err_q;
	logic                     first_q;

	logic                     div_start, div_done;
	mag_t                     div_a, div_b, quo, rem;
	logic                     load_out;
	logic                     gcd_found;
	logic signed [FULL_W-1:0] sn, sd;

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	assign req_pop  = (state_q == ST_IDLE) && !q_empty;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	// gcd known: either the smaller term is zero on entry, or a remainder hit zero
	assign gcd_found = (state_q == ST_GCD) &&
	                   ((first_q && small_q == '0) || (!first_q && div_done && rem == '0));

	always_comb begin
		div_start = 1'b0;
		div_a     = big_q;
		div_b     = small_q;
		unique case (state_q)
			ST_GCD: begin
				if (first_q) begin
					// first Euclid step, or straight to the numerator divide
					div_start = 1'b1;
					if (small_q == '0) begin
						div_a = cur_q.num_mag;
						div_b = big_q;
					end
				end else if (div_done) begin
					div_start = 1'b1;
					if (rem != '0) begin
						div_a = small_q;
						div_b = rem;
					end else begin
						div_a = cur_q.num_mag;
						div_b = small_q;
					end
				end
			end
			ST_NUMQ: begin
				div_start = div_done;
				div_a     = cur_q.den_mag;
				div_b     = g_q;
			end
			default: ;
		endcase
	end

	assign sn = cur_q.num_neg ? -$signed(FULL_W'(nq_q)) : $signed(FULL_W'(nq_q));
	assign sd = cur_q.den_neg ? -$signed(FULL_W'(quo)) : $signed(FULL_W'(quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (req.kind != KIND_REDUCE)
							state_q <= ST_DONE;
						else
							state_q <= ST_GCD;
					end
				end
				ST_GCD:  if (gcd_found) state_q <= ST_NUMQ;
				ST_NUMQ: if (div_done) state_q <= ST_DENQ;
				ST_DENQ: if (div_done) state_q <= ST_DONE;
				ST_DONE: if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// high in the first cycle of ST_GCD
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			first_q <= 1'b0;
		else
			first_q <= req_pop && req.kind == KIND_REDUCE;
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			cur_q   <= req;
			big_q   <= (req.num_mag > req.den_mag) ? req.num_mag : req.den_mag;
			small_q <= (req.num_mag > req.den_mag) ? req.den_mag : req.num_mag;
			fin_num_q <= '0;
			fin_den_q <= '0;
			fin_err_q <= (req.kind == KIND_ZERODEN);
		end
		if (state_q == ST_GCD && !first_q && div_done && rem != '0) begin
			big_q   <= small_q;
			small_q <= rem;
		end
		if (gcd_found)
			g_q <= first_q ? big_q : small_q;
		if (state_q == ST_NUMQ && div_done)
			nq_q <= quo;
		if (state_q == ST_DENQ && div_done) begin
			fin_num_q <= NUM_OUT_W'(sn);
			fin_den_q <= DEN_OUT_W'(sd);
		end
		if (load_out) begin
			res_num  <= fin_num_q;
			res_den  <= fin_den_q;
			zero_den <= fin_err_q;
		end
	end

endmodule

### hw/rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit - fraction add/sub/mul/div/reciprocal with gcd
// Cross products in a two-stage front, Euclid reduction in an iterative back.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | push / full          | op, a_num, a_den, b_num, b_den
//  result   | empty / pop          | res_num, res_den, zero_den
//
//  The front takes one request per cycle while full is low, into a two-entry
//  queue; the back reduces one request at a time. Each divider pass
//  produces one quotient bit per cycle (MAG_W = 33 bits).
//  Zero-denominator and undefined-op requests skip the divider.
//  arst_n clears all control state; the result register holds until popped.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [rau_pkg::OP_W-1:0]             op,
	input  rau_pkg::operand_t                    a_num,
	input  rau_pkg::operand_t                    a_den,
	input  rau_pkg::operand_t                    b_num,
	input  rau_pkg::operand_t                    b_den,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [rau_pkg::NUM_OUT_W-1:0] res_num,
	output logic signed [rau_pkg::DEN_OUT_W-1:0] res_den,
	output logic                                 zero_den
);
	import rau_pkg::*;

	logic req_push, req_full, req_pop, q_empty;
	req_t req_in, req_out;

	// front: products and classification
	rau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.req_push (req_push),
		.req      (req_in),
		.req_full (req_full)
	);

	// decoupling queue
	rau_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (req_push),
		.wr_data (req_in),
		.q_full  (req_full),
		.rd      (req_pop),
		.rd_data (req_out),
		.q_empty (q_empty)
	);

	// back: gcd reduction and result register
	rau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_out),
		.q_empty  (q_empty),
		.req_pop  (req_pop),
		.pop      (pop),
		.empty    (empty),
		.res_num  (res_num),
		.res_den  (res_den),
		.zero_den (zero_den)
	);

endmodule
